### rtl/mtfp_pkg.sv
// Shared types and constants for the multi-tank fuel pump sequencer.
`default_nettype none

package mtfp_pkg;

   localparam int unsigned LEVEL_W = 16;
   localparam int unsigned POINT_W = 10;
   localparam int unsigned DELAY_W = 16;
   localparam int unsigned TIME_W  = 32;
   localparam int unsigned STAGE_W = 3;
   localparam int unsigned CSR_IDX_W  = 3;
   localparam int unsigned CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_CRIT_LOW     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TANK1_POINT  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TANK2_POINT  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_TANK3_POINT  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_PUMP_DELAY   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_THROTTLE_ALL = 3'd5;

   localparam logic [POINT_W-1:0] CRIT_LOW_RST     = 10'd70;
   localparam logic [POINT_W-1:0] TANK1_POINT_RST  = 10'd200;
   localparam logic [POINT_W-1:0] TANK2_POINT_RST  = 10'd250;
   localparam logic [POINT_W-1:0] TANK3_POINT_RST  = 10'd600;
   localparam logic [DELAY_W-1:0] PUMP_DELAY_RST   = 16'd15000;
   localparam logic [POINT_W-1:0] THROTTLE_ALL_RST = 10'd850;

   localparam logic [LEVEL_W:0] FULL_SCALE = 17'd1000;

   localparam logic [STAGE_W-1:0] STAGE_1 = 3'd1;
   localparam logic [STAGE_W-1:0] STAGE_2 = 3'd2;
   localparam logic [STAGE_W-1:0] STAGE_3 = 3'd3;
   localparam logic [STAGE_W-1:0] STAGE_4 = 3'd4;

   typedef struct packed {
      logic [POINT_W-1:0] crit_low;
      logic [POINT_W-1:0] tank1_point;
      logic [POINT_W-1:0] tank2_point;
      logic [POINT_W-1:0] tank3_point;
      logic [DELAY_W-1:0] pump_delay_ms;
      logic [POINT_W-1:0] throttle_all_on;
   } cfg_type;

   typedef struct packed {
      logic [LEVEL_W-1:0] level_tank1;
      logic [LEVEL_W-1:0] level_tank2;
      logic [LEVEL_W-1:0] level_tank3;
      logic [POINT_W-1:0] throttle_permille;
      logic               ignition_on;
      logic               manual_mode;
      logic               emergency_release;
      logic [TIME_W-1:0]  now_ms;
   } tick_type;

   typedef struct packed {
      logic [2:0]         pump_cmd;
      logic [STAGE_W-1:0] fuel_stage;
   } result_type;

endpackage

`default_nettype wire

### rtl/mtfp_csr.sv
// Configuration register bank for the fuel pump sequencer.
`default_nettype none

module mtfp_csr
   import mtfp_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  wr_en,
   input  wire logic [CSR_IDX_W-1:0]  wr_index,
   input  wire logic [CSR_DATA_W-1:0] wr_data,
   output cfg_type                    cfg
);

   cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.crit_low        <= CRIT_LOW_RST;
         cfg_ff.tank1_point     <= TANK1_POINT_RST;
         cfg_ff.tank2_point     <= TANK2_POINT_RST;
         cfg_ff.tank3_point     <= TANK3_POINT_RST;
         cfg_ff.pump_delay_ms   <= PUMP_DELAY_RST;
         cfg_ff.throttle_all_on <= THROTTLE_ALL_RST;
      end else if (wr_en) begin
         unique case (wr_index)
            CSR_CRIT_LOW:     cfg_ff.crit_low        <= wr_data[POINT_W-1:0];
            CSR_TANK1_POINT:  cfg_ff.tank1_point     <= wr_data[POINT_W-1:0];
            CSR_TANK2_POINT:  cfg_ff.tank2_point     <= wr_data[POINT_W-1:0];
            CSR_TANK3_POINT:  cfg_ff.tank3_point     <= wr_data[POINT_W-1:0];
            CSR_PUMP_DELAY:   cfg_ff.pump_delay_ms   <= wr_data[DELAY_W-1:0];
            CSR_THROTTLE_ALL: cfg_ff.throttle_all_on <= wr_data[POINT_W-1:0];
            default: ;
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

### rtl/mtfp_seq.sv
// Pump sequencer state and per-tick decision logic.
`default_nettype none

module mtfp_seq
   import mtfp_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire cfg_type  cfg,
   input  wire logic     step,
   input  wire tick_type tick,
   output result_type    res
);

   logic [STAGE_W-1:0] stage_ff, stage_in;
   logic [2:0]         pump_ff, pump_in;
   logic [TIME_W-1:0]  last_ff, last_in;
   logic               ign_prev_ff, ign_prev_in;
   logic               man_prev_ff, man_prev_in;

   logic               sel_en;
   logic [2:0]         sel_mask;
   logic               all_on;
   logic [STAGE_W-1:0] seq_stage;
   logic [TIME_W-1:0]  elapsed;
   logic               delay_ok;
   logic               l3_above_t3, l1_above_t1, l3_above_crit, l3_below_crit;
   logic               l2_above_t2, l1_above_crit, l2_above_crit, l1_above_l2;
   logic               prefer_tank1;

   assign elapsed  = tick.now_ms - last_ff;
   assign delay_ok = elapsed > {{(TIME_W-DELAY_W){1'b0}}, cfg.pump_delay_ms};

   assign l3_above_t3   = tick.level_tank3 > {6'd0, cfg.tank3_point};
   assign l1_above_t1   = tick.level_tank1 > {6'd0, cfg.tank1_point};
   assign l2_above_t2   = tick.level_tank2 > {6'd0, cfg.tank2_point};
   assign l3_above_crit = tick.level_tank3 > {6'd0, cfg.crit_low};
   assign l3_below_crit = tick.level_tank3 < {6'd0, cfg.crit_low};
   assign l1_above_crit = tick.level_tank1 > {6'd0, cfg.crit_low};
   assign l2_above_crit = tick.level_tank2 > {6'd0, cfg.crit_low};
   assign l1_above_l2   = tick.level_tank1 > tick.level_tank2;
   assign prefer_tank1  = ({1'b0, tick.level_tank1} + {7'd0, cfg.tank3_point})
                          > ({1'b0, tick.level_tank3} + FULL_SCALE);

   // stage selection: which pump to run, all pumps on, or advance
   always_comb begin
      sel_en    = 1'b0;
      sel_mask  = 3'b000;
      all_on    = 1'b0;
      seq_stage = stage_ff;
      unique case (stage_ff)
         STAGE_1: begin
            if (l3_above_t3) begin
               sel_en   = 1'b1;
               sel_mask = 3'b100;
            end else begin
               seq_stage = STAGE_2;
            end
         end
         STAGE_2: begin
            if (l1_above_t1) begin
               sel_en   = 1'b1;
               sel_mask = (l3_above_crit && !prefer_tank1) ? 3'b100 : 3'b001;
            end else begin
               seq_stage = STAGE_3;
            end
         end
         STAGE_3: begin
            if (l3_below_crit) begin
               if (l2_above_t2) begin
                  sel_en   = 1'b1;
                  sel_mask = 3'b010;
               end else begin
                  seq_stage = STAGE_4;
               end
            end else begin
               sel_en   = 1'b1;
               sel_mask = 3'b100;
            end
         end
         STAGE_4: begin
            if (l3_below_crit) begin
               if (l1_above_crit && (!l2_above_crit || l1_above_l2)) begin
                  sel_en   = 1'b1;
                  sel_mask = 3'b001;
               end else if (l2_above_crit) begin
                  sel_en   = 1'b1;
                  sel_mask = 3'b010;
               end else begin
                  all_on = 1'b1;
               end
            end else begin
               sel_en   = 1'b1;
               sel_mask = 3'b100;
            end
         end
         default: ;
      endcase
   end

   always_comb begin
      logic [2:0] p;
      p           = pump_ff;
      stage_in    = stage_ff;
      last_in     = last_ff;
      ign_prev_in = ign_prev_ff;
      man_prev_in = man_prev_ff;
      if (tick.emergency_release) begin
         p = 3'b000;
      end else begin
         if (tick.ignition_on != ign_prev_ff) begin
            ign_prev_in = tick.ignition_on;
            if (!tick.ignition_on) p = 3'b000;
         end
         if (tick.manual_mode != man_prev_ff) begin
            man_prev_in = tick.manual_mode;
            if (!tick.manual_mode) p = 3'b000;
         end
         if (!tick.manual_mode && tick.ignition_on) begin
            if (tick.throttle_permille > cfg.throttle_all_on) begin
               p = 3'b111;
            end else begin
               stage_in = seq_stage;
               if (all_on) begin
                  p = 3'b111;
               end else if (sel_en && delay_ok) begin
                  if ((p & ~sel_mask) != 3'b000) begin
                     p = p & sel_mask;
                  end else if ((p & sel_mask) == 3'b000) begin
                     p       = p | sel_mask;
                     last_in = tick.now_ms;
                  end
               end
            end
         end
      end
      pump_in = p;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff    <= STAGE_1;
         pump_ff     <= 3'b000;
         last_ff     <= '0;
         ign_prev_ff <= 1'b0;
         man_prev_ff <= 1'b0;
      end else if (step) begin
         stage_ff    <= stage_in;
         pump_ff     <= pump_in;
         last_ff     <= last_in;
         ign_prev_ff <= ign_prev_in;
         man_prev_ff <= man_prev_in;
      end
   end

   assign res.pump_cmd   = pump_in;
   assign res.fuel_stage = stage_in;

endmodule

`default_nettype wire

### rtl/multi_tank_fuel_pump_sequencer.sv
// Top level of the multi-tank fuel pump sequencer: request and response registers.
// A result passes through the request register, then the response register.
// Throughput: one tick per cycle unless stalled; state feedback closes each step.
// Reset: synchronous; clears both registers' valid flags, returns the sequencer
// to stage one with all pumps off and reloads configuration defaults.
`default_nettype none

module multi_tank_fuel_pump_sequencer
   import mtfp_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,

   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic [LEVEL_W-1:0]    req_level_tank1,
   input  wire logic [LEVEL_W-1:0]    req_level_tank2,
   input  wire logic [LEVEL_W-1:0]    req_level_tank3,
   input  wire logic [POINT_W-1:0]    req_throttle_permille,
   input  wire logic                  req_ignition_on,
   input  wire logic                  req_manual_mode,
   input  wire logic                  req_emergency_release,
   input  wire logic [TIME_W-1:0]     req_now_ms,

   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic                       rsp_pump1_cmd,
   output logic                       rsp_pump2_cmd,
   output logic                       rsp_pump3_cmd,
   output logic [STAGE_W-1:0]         rsp_fuel_stage,

   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type    cfg;
   tick_type   tick_ff;
   logic       tick_valid_ff;
   result_type res_in, res_ff;
   logic       rsp_valid_ff;
   logic       out_free;
   logic       advance;

   assign csr_ready = 1'b1;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign advance   = tick_valid_ff && out_free;
   assign req_stall = tick_valid_ff && !out_free;

   mtfp_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_valid && csr_ready),
      .wr_index (csr_index),
      .wr_data  (csr_wdata),
      .cfg      (cfg)
   );

   mtfp_seq u_seq (
      .clock (clock),
      .reset (reset),
      .cfg   (cfg),
      .step  (advance),
      .tick  (tick_ff),
      .res   (res_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         tick_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         tick_ff.level_tank1       <= req_level_tank1;
         tick_ff.level_tank2       <= req_level_tank2;
         tick_ff.level_tank3       <= req_level_tank3;
         tick_ff.throttle_permille <= req_throttle_permille;
         tick_ff.ignition_on       <= req_ignition_on;
         tick_ff.manual_mode       <= req_manual_mode;
         tick_ff.emergency_release <= req_emergency_release;
         tick_ff.now_ms            <= req_now_ms;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= tick_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         res_ff <= res_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_pump1_cmd  = res_ff.pump_cmd[0];
   assign rsp_pump2_cmd  = res_ff.pump_cmd[1];
   assign rsp_pump3_cmd  = res_ff.pump_cmd[2];
   assign rsp_fuel_stage = res_ff.fuel_stage;

endmodule

`default_nettype wire
